/* src/normal_cdf_erfc_approx_top_defines.svh */
// Assertion macros shared by the normal CDF block.
`ifndef NORMAL_CDF_ERFC_APPROX_TOP_DEFINES_SVH
`define NORMAL_CDF_ERFC_APPROX_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define NCE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define NCE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/nce_pkg.sv */
// Shared types, widths and constants of the normal CDF pipeline.
`default_nettype none
package nce_pkg;

    typedef struct packed {
        logic valid;
        logic bad;
        logic below;
    } t_side;

    typedef struct packed {
        logic        valid;
        logic        bad;
        logic [24:0] prob;
    } t_res;

    localparam int ZQ_W         = 35;
    localparam int DIV_STEPS    = 35;
    localparam int UQ_W         = 31;
    localparam int PW           = 35;
    localparam int ZSQ_W        = 36;
    localparam int M_W          = 37;
    localparam int WHOLE_W      = 5;
    localparam int HORNER_TERMS = 12;

    localparam logic [31:0]      SQRT_HALF_Q32 = 32'd3037000500;
    localparam logic [ZQ_W-1:0]  ZCLAMP        = 35'h6_0000_0000;
    localparam logic [34:0]      U_BASE        = 35'h1_0000_0000;
    localparam logic [34:0]      U_REM0        = 35'h0_8000_0000;
    localparam logic [29:0]      LN2_Q30       = 30'd744261118;
    localparam logic [M_W-1:0]   BIG_LIM       = 37'd23816355776;
    localparam logic [30:0]      ACC_ONE       = 31'h4000_0000;
    localparam logic [24:0]      PROB_ONE      = 25'h100_0000;

    localparam logic signed [PW-1:0] POLY_COEF [10] = '{
        -35'sd1358833410, 35'sd1073767250, 35'sd401678183, 35'sd103921222,
        -35'sd200025281, 35'sd299432310, -35'sd1218915992, 35'sd1598281745,
        -35'sd882779235, 35'sd183473240
    };

    // floor(2^32 / d) for d = 1 .. 12.
    localparam logic [32:0] RECIP [HORNER_TERMS] = '{
        33'd4294967296, 33'd2147483648, 33'd1431655765, 33'd1073741824,
        33'd858993459, 33'd715827882, 33'd613566756, 33'd536870912,
        33'd477218588, 33'd429496729, 33'd390451572, 33'd357913941
    };

endpackage
`default_nettype wire

/* src/nce_zdiv.sv */
// Front end: difference, scaling by sqrt(1/2) and the bit-per-stage divide by sigma.
`default_nettype none
module nce_zdiv (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_valid,
    input  logic [31:0]               i_x_value,
    input  logic [31:0]               i_mean,
    input  logic [31:0]               i_std_dev,
    output nce_pkg::t_side            o_side,
    output logic [nce_pkg::ZQ_W-1:0]  o_zq
);
    import nce_pkg::*;

    logic signed [32:0] w_diff;
    logic [32:0]        w_dmag;
    t_side              w_in_side;

    t_side       r_a_side;
    logic [32:0] r_a_dmag;
    logic [30:0] r_a_sv;

    t_side       r_b_side;
    logic [47:0] r_b_plo;
    logic [48:0] r_b_phi;
    logic [30:0] r_b_sv;

    logic [63:0] w_num;

    t_side           r_side [DIV_STEPS+1];
    logic [30:0]     r_rem  [DIV_STEPS+1];
    logic [34:0]     r_num  [DIV_STEPS+1];
    logic [ZQ_W-1:0] r_q    [DIV_STEPS+1];
    logic [30:0]     r_sv   [DIV_STEPS+1];
    logic            r_ovf  [DIV_STEPS+1];

    assign w_diff = $signed({i_x_value[31], i_x_value}) - $signed({i_mean[31], i_mean});
    assign w_dmag = w_diff[32] ? 33'(-w_diff) : 33'(w_diff);
    assign w_in_side.valid = i_valid;
    assign w_in_side.bad   = i_std_dev[31] || (i_std_dev == 32'd0);
    assign w_in_side.below = w_diff[32];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_side <= '0;
            r_b_side <= '0;
            r_side[0] <= '0;
        end else if (i_en) begin
            r_a_side <= w_in_side;
            r_b_side <= r_a_side;
            r_side[0] <= r_b_side;
        end
    end

    assign w_num = 64'({r_b_phi, 16'b0}) + 64'(r_b_plo);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_dmag <= w_dmag;
            r_a_sv   <= i_std_dev[30:0];
            r_b_plo  <= 48'(r_a_dmag[15:0]) * 48'(SQRT_HALF_Q32);
            r_b_phi  <= 49'(r_a_dmag[32:16]) * 49'(SQRT_HALF_Q32);
            r_b_sv   <= r_a_sv;
            r_rem[0] <= 31'(w_num[63:35]);
            r_num[0] <= w_num[34:0];
            r_q[0]   <= '0;
            r_sv[0]  <= r_b_sv;
            r_ovf[0] <= {2'b0, w_num[63:35]} >= r_b_sv;
        end
    end

    for (genvar s = 0; s < DIV_STEPS; s++) begin : g_div
        localparam int K = DIV_STEPS - 1 - s;
        logic [31:0] w_trial;
        logic        w_ge;

        assign w_trial = {r_rem[s], r_num[s][K]};
        assign w_ge    = w_trial >= {1'b0, r_sv[s]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_side[s+1] <= '0;
            end else if (i_en) begin
                r_side[s+1] <= r_side[s];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s+1] <= w_ge ? 31'(w_trial - {1'b0, r_sv[s]}) : 31'(w_trial);
                r_q[s+1]   <= {r_q[s][ZQ_W-2:0], w_ge};
                r_num[s+1] <= r_num[s];
                r_sv[s+1]  <= r_sv[s];
                r_ovf[s+1] <= r_ovf[s];
            end
        end
    end

    assign o_side = r_side[DIV_STEPS];
    assign o_zq   = (r_ovf[DIV_STEPS] || (r_q[DIV_STEPS] > ZCLAMP)) ? ZCLAMP : r_q[DIV_STEPS];

endmodule
`default_nettype wire

/* src/nce_udiv.sv */
// Reciprocal stage: t = 1 / (1 + z/2) in Q30, one quotient bit per stage.
`default_nettype none
module nce_udiv (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  nce_pkg::t_side            i_side,
    input  logic [nce_pkg::ZQ_W-1:0]  i_zq,
    output nce_pkg::t_side            o_side,
    output logic [nce_pkg::UQ_W-1:0]  o_uq,
    output logic [nce_pkg::ZQ_W-1:0]  o_zq
);
    import nce_pkg::*;

    t_side           r_side [UQ_W+1];
    logic [34:0]     r_d    [UQ_W+1];
    logic [34:0]     r_rem  [UQ_W+1];
    logic [UQ_W-1:0] r_q    [UQ_W+1];
    logic [ZQ_W-1:0] r_zq   [UQ_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side[0] <= '0;
        end else if (i_en) begin
            r_side[0] <= i_side;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d[0]   <= U_BASE + {1'b0, i_zq[ZQ_W-1:1]};
            r_rem[0] <= U_REM0;
            r_q[0]   <= '0;
            r_zq[0]  <= i_zq;
        end
    end

    for (genvar s = 0; s < UQ_W; s++) begin : g_div
        logic [35:0] w_trial;
        logic        w_ge;

        assign w_trial = {r_rem[s], 1'b0};
        assign w_ge    = w_trial >= {1'b0, r_d[s]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_side[s+1] <= '0;
            end else if (i_en) begin
                r_side[s+1] <= r_side[s];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s+1] <= w_ge ? 35'(w_trial - {1'b0, r_d[s]}) : 35'(w_trial);
                r_q[s+1]   <= {r_q[s][UQ_W-2:0], w_ge};
                r_d[s+1]   <= r_d[s];
                r_zq[s+1]  <= r_zq[s];
            end
        end
    end

    assign o_side = r_side[UQ_W];
    assign o_uq   = r_q[UQ_W];
    assign o_zq   = r_zq[UQ_W];

endmodule
`default_nettype wire

/* src/nce_poly.sv */
// Exponent polynomial in t by Horner steps, z squared, and the clamped exponent magnitude.
`default_nettype none
module nce_poly (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  nce_pkg::t_side            i_side,
    input  logic [nce_pkg::UQ_W-1:0]  i_uq,
    input  logic [nce_pkg::ZQ_W-1:0]  i_zq,
    output nce_pkg::t_side            o_side,
    output logic [nce_pkg::UQ_W-1:0]  o_uq,
    output logic [nce_pkg::M_W-1:0]   o_m
);
    import nce_pkg::*;

    localparam int STEPS = 9;

    logic [62:0] w_zsq_full;

    t_side                r_side [STEPS+1];
    logic signed [PW-1:0] r_poly [STEPS+1];
    logic [UQ_W-1:0]      r_uq   [STEPS+1];
    logic [ZSQ_W-1:0]     r_zsq  [STEPS+1];

    t_side                r_sa   [STEPS];
    logic [47:0]          r_pa   [STEPS];
    logic [47:0]          r_pb   [STEPS];
    logic                 r_neg  [STEPS];
    logic [UQ_W-1:0]      r_ua   [STEPS];
    logic [ZSQ_W-1:0]     r_za   [STEPS];

    logic signed [37:0]   w_expo;
    t_side                r_o_side;
    logic [UQ_W-1:0]      r_o_uq;
    logic [M_W-1:0]       r_o_m;

    assign w_zsq_full = 63'(i_zq[ZQ_W-1:4]) * 63'(i_zq[ZQ_W-1:4]) + 63'(2**25);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side[0] <= '0;
        end else if (i_en) begin
            r_side[0] <= i_side;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_poly[0] <= POLY_COEF[9];
            r_uq[0]   <= i_uq;
            r_zsq[0]  <= ZSQ_W'(w_zsq_full >> 26);
        end
    end

    for (genvar j = 0; j < STEPS; j++) begin : g_step
        localparam int CI = STEPS - 1 - j;
        logic              w_neg;
        logic [33:0]       w_mag;
        logic [64:0]       w_prod;
        logic [34:0]       w_rnd;
        logic signed [PW-1:0] w_term;

        assign w_neg  = r_poly[j][PW-1];
        assign w_mag  = w_neg ? 34'(-r_poly[j]) : 34'(r_poly[j]);
        assign w_prod = {r_pa[j], 17'b0} + 65'(r_pb[j]);
        assign w_rnd  = 35'((w_prod + 65'(2**29)) >> 30);
        assign w_term = r_neg[j] ? -$signed(w_rnd) : $signed(w_rnd);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sa[j]     <= '0;
                r_side[j+1] <= '0;
            end else if (i_en) begin
                r_sa[j]     <= r_side[j];
                r_side[j+1] <= r_sa[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_pa[j]     <= 48'(w_mag[33:17]) * 48'(r_uq[j]);
                r_pb[j]     <= 48'(w_mag[16:0]) * 48'(r_uq[j]);
                r_neg[j]    <= w_neg;
                r_ua[j]     <= r_uq[j];
                r_za[j]     <= r_zsq[j];
                r_poly[j+1] <= POLY_COEF[CI] + w_term;
                r_uq[j+1]   <= r_ua[j];
                r_zsq[j+1]  <= r_za[j];
            end
        end
    end

    assign w_expo = $signed({{3{r_poly[STEPS][PW-1]}}, r_poly[STEPS]})
                  - $signed({2'b0, r_zsq[STEPS]});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_side <= '0;
        end else if (i_en) begin
            r_o_side <= r_side[STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_o_uq <= r_uq[STEPS];
            r_o_m  <= (w_expo > 38'sd0) ? '0 : M_W'(-w_expo);
        end
    end

    assign o_side = r_o_side;
    assign o_uq   = r_o_uq;
    assign o_m    = r_o_m;

endmodule
`default_nettype wire

/* src/nce_exp.sv */
// exp(-m) by range reduction and a Horner series, then the final product and probability.
`default_nettype none
module nce_exp (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  nce_pkg::t_side            i_side,
    input  logic [nce_pkg::UQ_W-1:0]  i_uq,
    input  logic [nce_pkg::M_W-1:0]   i_m,
    output nce_pkg::t_res             o_res
);
    import nce_pkg::*;

    t_side              r_w_side  [WHOLE_W+1];
    logic [34:0]        r_w_rem   [WHOLE_W+1];
    logic [WHOLE_W-1:0] r_w_whole [WHOLE_W+1];
    logic               r_w_big   [WHOLE_W+1];
    logic [UQ_W-1:0]    r_w_uq    [WHOLE_W+1];

    t_side              r_t1_side  [HORNER_TERMS];
    logic [60:0]        r_t1_prod  [HORNER_TERMS];
    logic [29:0]        r_t1_rest  [HORNER_TERMS];
    logic [WHOLE_W-1:0] r_t1_whole [HORNER_TERMS];
    logic               r_t1_big   [HORNER_TERMS];
    logic [UQ_W-1:0]    r_t1_uq    [HORNER_TERMS];

    t_side              r_t2_side  [HORNER_TERMS];
    logic [30:0]        r_t2_p     [HORNER_TERMS];
    logic [63:0]        r_t2_qm    [HORNER_TERMS];
    logic [29:0]        r_t2_rest  [HORNER_TERMS];
    logic [WHOLE_W-1:0] r_t2_whole [HORNER_TERMS];
    logic               r_t2_big   [HORNER_TERMS];
    logic [UQ_W-1:0]    r_t2_uq    [HORNER_TERMS];

    t_side              r_h_side  [1:HORNER_TERMS];
    logic [30:0]        r_h_acc   [1:HORNER_TERMS];
    logic [29:0]        r_h_rest  [1:HORNER_TERMS];
    logic [WHOLE_W-1:0] r_h_whole [1:HORNER_TERMS];
    logic               r_h_big   [1:HORNER_TERMS];
    logic [UQ_W-1:0]    r_h_uq    [1:HORNER_TERMS];

    t_side       r_e_side;
    logic [61:0] r_e_pe;

    logic [30:0] w_ex;
    logic [30:0] w_ev;
    logic [24:0] w_half_raw;
    logic [24:0] w_half;
    t_res        r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_side[0] <= '0;
        end else if (i_en) begin
            r_w_side[0] <= i_side;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_w_rem[0]   <= i_m[34:0];
            r_w_big[0]   <= i_m >= BIG_LIM;
            r_w_whole[0] <= '0;
            r_w_uq[0]    <= i_uq;
        end
    end

    for (genvar s = 0; s < WHOLE_W; s++) begin : g_whole
        localparam int K = WHOLE_W - 1 - s;
        localparam logic [34:0] C = 35'(LN2_Q30) << K;
        logic w_ge;

        assign w_ge = r_w_rem[s] >= C;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_w_side[s+1] <= '0;
            end else if (i_en) begin
                r_w_side[s+1] <= r_w_side[s];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_w_rem[s+1]   <= w_ge ? r_w_rem[s] - C : r_w_rem[s];
                r_w_whole[s+1] <= {r_w_whole[s][WHOLE_W-2:0], w_ge};
                r_w_big[s+1]   <= r_w_big[s];
                r_w_uq[s+1]    <= r_w_uq[s];
            end
        end
    end

    for (genvar j = 0; j < HORNER_TERMS; j++) begin : g_horner
        localparam int TERM = HORNER_TERMS - j;
        localparam logic [35:0] TERM_V = 36'(TERM);
        t_side              w_side_in;
        logic [30:0]        w_acc_in;
        logic [29:0]        w_rest_in;
        logic [WHOLE_W-1:0] w_whole_in;
        logic               w_big_in;
        logic [UQ_W-1:0]    w_uq_in;
        logic [31:0]        w_q0;
        logic [35:0]        w_r;
        logic [31:0]        w_q;

        if (j == 0) begin : g_first
            assign w_side_in  = r_w_side[WHOLE_W];
            assign w_acc_in   = ACC_ONE;
            assign w_rest_in  = r_w_rem[WHOLE_W][29:0];
            assign w_whole_in = r_w_whole[WHOLE_W];
            assign w_big_in   = r_w_big[WHOLE_W];
            assign w_uq_in    = r_w_uq[WHOLE_W];
        end else begin : g_next
            assign w_side_in  = r_h_side[j];
            assign w_acc_in   = r_h_acc[j];
            assign w_rest_in  = r_h_rest[j];
            assign w_whole_in = r_h_whole[j];
            assign w_big_in   = r_h_big[j];
            assign w_uq_in    = r_h_uq[j];
        end

        assign w_q0 = r_t2_qm[j][63:32];
        assign w_r  = 36'(r_t2_p[j]) - 36'(w_q0) * TERM_V;
        assign w_q  = w_q0 + 32'(w_r >= TERM_V);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_t1_side[j]  <= '0;
                r_t2_side[j]  <= '0;
                r_h_side[j+1] <= '0;
            end else if (i_en) begin
                r_t1_side[j]  <= w_side_in;
                r_t2_side[j]  <= r_t1_side[j];
                r_h_side[j+1] <= r_t2_side[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_t1_prod[j]   <= 61'(w_rest_in) * 61'(w_acc_in);
                r_t1_rest[j]   <= w_rest_in;
                r_t1_whole[j]  <= w_whole_in;
                r_t1_big[j]    <= w_big_in;
                r_t1_uq[j]     <= w_uq_in;
                r_t2_p[j]      <= r_t1_prod[j][60:30];
                r_t2_qm[j]     <= 64'(r_t1_prod[j][60:30]) * 64'(RECIP[TERM-1]);
                r_t2_rest[j]   <= r_t1_rest[j];
                r_t2_whole[j]  <= r_t1_whole[j];
                r_t2_big[j]    <= r_t1_big[j];
                r_t2_uq[j]     <= r_t1_uq[j];
                r_h_acc[j+1]   <= 31'(32'(ACC_ONE) - w_q);
                r_h_rest[j+1]  <= r_t2_rest[j];
                r_h_whole[j+1] <= r_t2_whole[j];
                r_h_big[j+1]   <= r_t2_big[j];
                r_h_uq[j+1]    <= r_t2_uq[j];
            end
        end
    end

    assign w_ex = r_h_big[HORNER_TERMS] ? '0
                : (r_h_acc[HORNER_TERMS] >> r_h_whole[HORNER_TERMS]);

    assign w_ev       = 31'((r_e_pe + 62'(2**29)) >> 30);
    assign w_half_raw = 25'((32'(w_ev) + 32'd64) >> 7);
    assign w_half     = (w_half_raw > PROB_ONE) ? PROB_ONE : w_half_raw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_side  <= '0;
            r_res.valid <= 1'b0;
        end else if (i_en) begin
            r_e_side  <= r_h_side[HORNER_TERMS];
            r_res.valid <= r_e_side.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_e_pe    <= 62'(r_h_uq[HORNER_TERMS]) * 62'(w_ex);
            r_res.bad <= r_e_side.bad;
            if (r_e_side.bad) begin
                r_res.prob <= '0;
            end else if (r_e_side.below) begin
                r_res.prob <= w_half;
            end else begin
                r_res.prob <= PROB_ONE - w_half;
            end
        end
    end

    assign o_res = r_res;

endmodule
`default_nettype wire

/* src/normal_cdf_erfc_approx_top.sv */
// Normal CDF evaluator: every accepted transaction yields one result, one transaction per cycle
// while the skid buffer is empty. The pipeline includes the two bit-per-stage dividers (35 stages
// for the scaled argument, 31 for the reciprocal), the nine Horner steps of the exponent polynomial
// and the twelve Horner steps of the exp series; everything is pipelined with a global advance
// enable and a one-entry skid buffer behind the output register, so the input keeps flowing
// while one result waits to be taken. A nonpositive standard deviation gives probability zero
// with the error flag set.
`default_nettype none
`include "normal_cdf_erfc_approx_top_defines.svh"
module normal_cdf_erfc_approx_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_x_value,
    input  logic [31:0] i_mean,
    input  logic [31:0] i_std_dev,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [24:0] o_probability,
    output logic        o_bad_sigma
);
    import nce_pkg::*;

    logic            w_en;
    t_side           w_z_side;
    logic [ZQ_W-1:0] w_z_zq;
    t_side           w_u_side;
    logic [UQ_W-1:0] w_u_uq;
    logic [ZQ_W-1:0] w_u_zq;
    t_side           w_p_side;
    logic [UQ_W-1:0] w_p_uq;
    logic [M_W-1:0]  w_p_m;
    t_res            w_tail;

    logic        r_out_valid;
    logic [24:0] r_out_prob;
    logic        r_out_bad;
    logic        r_skid_valid;
    logic [24:0] r_skid_prob;
    logic        r_skid_bad;

    assign w_en = !r_skid_valid;

    nce_zdiv u_zdiv (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_en),
        .i_valid   (i_valid),
        .i_x_value (i_x_value),
        .i_mean    (i_mean),
        .i_std_dev (i_std_dev),
        .o_side    (w_z_side),
        .o_zq      (w_z_zq)
    );

    nce_udiv u_udiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_side  (w_z_side),
        .i_zq    (w_z_zq),
        .o_side  (w_u_side),
        .o_uq    (w_u_uq),
        .o_zq    (w_u_zq)
    );

    nce_poly u_poly (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_side  (w_u_side),
        .i_uq    (w_u_uq),
        .i_zq    (w_u_zq),
        .o_side  (w_p_side),
        .o_uq    (w_p_uq),
        .o_m     (w_p_m)
    );

    nce_exp u_exp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_side  (w_p_side),
        .i_uq    (w_p_uq),
        .i_m     (w_p_m),
        .o_res   (w_tail)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (i_ready) begin
                r_out_prob   <= r_skid_prob;
                r_out_bad    <= r_skid_bad;
                r_skid_valid <= 1'b0;
            end
        end else if (!r_out_valid || i_ready) begin
            r_out_valid <= w_tail.valid;
            r_out_prob  <= w_tail.prob;
            r_out_bad   <= w_tail.bad;
        end else if (w_tail.valid) begin
            r_skid_valid <= 1'b1;
            r_skid_prob  <= w_tail.prob;
            r_skid_bad   <= w_tail.bad;
        end
    end

    assign o_ready       = w_en;
    assign o_valid       = r_out_valid;
    assign o_probability = r_out_prob;
    assign o_bad_sigma   = r_out_bad;

    `NCE_ASSERT_NOW(a_skid_behind_out, r_skid_valid, r_out_valid, "skid holds data with empty output")
    `NCE_ASSERT_NOW(a_prob_range, r_out_valid, r_out_prob <= PROB_ONE, "probability above one")
    `NCE_ASSERT_NOW(a_bad_is_zero, r_out_valid && r_out_bad, r_out_prob == 25'd0, "bad sigma with nonzero probability")
    `NCE_ASSERT_NEXT(a_skid_catch, r_out_valid && !i_ready && !r_skid_valid && w_tail.valid, r_skid_valid, "stalled result not captured")

endmodule
`default_nettype wire

/* dv/normal_cdf_erfc_approx_top_tb.sv */
// Self-checking testbench for the normal CDF evaluator: directed table plus random transactions.
`default_nettype none
module normal_cdf_erfc_approx_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint CYCLE_LIMIT = 2000000;
    localparam int RANDOM_ITEMS = 1250;

    typedef struct {
        logic [31:0] x_value;
        logic [31:0] mean;
        logic [31:0] std_dev;
        logic        known;
        logic [24:0] prob;
        logic        bad;
    } t_cdf_row;

    typedef struct {
        logic [24:0] prob;
        logic        bad;
    } t_cdf_res;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [31:0] i_x_value;
    logic [31:0] i_mean;
    logic [31:0] i_std_dev;
    logic        o_valid;
    logic        i_ready;
    logic [24:0] o_probability;
    logic        o_bad_sigma;

    t_cdf_res    pending_q[$];
    int          error_count;
    longint      cycle_count;
    logic        stim_done;
    t_cdf_row    directed_rows[$];

    normal_cdf_erfc_approx_top dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_x_value(i_x_value),
        .i_mean(i_mean),
        .i_std_dev(i_std_dev),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_probability(o_probability),
        .o_bad_sigma(o_bad_sigma)
    );

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    function automatic longint q30_scale(longint sval, longint unsigned uq);
        longint unsigned mag;
        longint unsigned prod;
        mag = (sval < 0) ? longint'(-sval) : longint'(sval);
        prod = (mag * uq + (64'd1 << 29)) >> 30;
        return (sval < 0) ? -longint'(prod) : longint'(prod);
    endfunction

    function automatic longint unsigned exp_neg(longint unsigned mq);
        longint unsigned whole;
        longint unsigned rest;
        longint unsigned acc;
        whole = mq / 64'd744261118;
        rest = mq - whole * 64'd744261118;
        acc = 64'd1 << 30;
        for (int k = 12; k >= 1; k--) begin
            acc = (64'd1 << 30) - ((rest * acc) >> 30) / longint'(k);
        end
        if (whole > 31) begin
            return 0;
        end
        return acc >> whole;
    endfunction

    function automatic t_cdf_res normal_cdf(logic [31:0] xr, logic [31:0] mr, logic [31:0] sr);
        longint coef[10];
        t_cdf_res res;
        longint xv;
        longint mv;
        longint sv;
        longint diff;
        longint poly;
        longint expo;
        longint unsigned dmag;
        longint unsigned zq;
        longint unsigned uq;
        longint unsigned z28;
        longint unsigned zsq;
        longint unsigned ex;
        longint unsigned ev;
        longint unsigned half;
        coef = '{-1358833410, 1073767250, 401678183, 103921222, -200025281,
                 299432310, -1218915992, 1598281745, -882779235, 183473240};
        xv = longint'(signed'(xr));
        mv = longint'(signed'(mr));
        sv = longint'(signed'(sr));
        if (sv <= 0) begin
            res.prob = '0;
            res.bad = 1'b1;
            return res;
        end
        diff = xv - mv;
        dmag = (diff < 0) ? longint'(-diff) : longint'(diff);
        zq = (dmag * 64'd3037000500) / longint'(sv);
        if (zq > (64'd6 << 32)) begin
            zq = 64'd6 << 32;
        end
        uq = (64'd1 << 62) / ((64'd1 << 32) + (zq >> 1));
        poly = coef[9];
        for (int k = 8; k >= 0; k--) begin
            poly = coef[k] + q30_scale(poly, uq);
        end
        z28 = zq >> 4;
        zsq = (z28 * z28 + (64'd1 << 25)) >> 26;
        expo = poly - longint'(zsq);
        if (expo > 0) begin
            expo = 0;
        end
        ex = exp_neg(longint'(-expo));
        ev = (uq * ex + (64'd1 << 29)) >> 30;
        half = (ev + 64) >> 7;
        if (half > 64'd16777216) begin
            half = 64'd16777216;
        end
        res.prob = (diff < 0) ? half[24:0] : 25'(64'd16777216 - half);
        res.bad = 1'b0;
        return res;
    endfunction

    function automatic int gap_length();
        if ($urandom_range(0, 19) == 0) begin
            return $urandom_range(10, 60);
        end
        if ($urandom_range(0, 2) == 0) begin
            return $urandom_range(1, 3);
        end
        return 0;
    endfunction

    function automatic logic [31:0] random_sigma();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return 32'(-$urandom_range(0, 1000000));
            2: return 32'($urandom_range(1, 4000));
            3: return 32'($urandom_range(1, 32'h7fff_ffff));
            default: return 32'($urandom_range(32'h4000, 32'h80000));
        endcase
    endfunction

    task automatic add_row(logic [31:0] xv, logic [31:0] mv, logic [31:0] sv,
                           logic known, logic [24:0] prob, logic bad);
        t_cdf_row row;
        row.x_value = xv;
        row.mean = mv;
        row.std_dev = sv;
        row.known = known;
        row.prob = prob;
        row.bad = bad;
        directed_rows.push_back(row);
    endtask

    task automatic send_item(logic [31:0] xv, logic [31:0] mv, logic [31:0] sv,
                             logic known, logic [24:0] prob, logic bad);
        t_cdf_res res;
        int gap;
        gap = gap_length();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_x_value <= xv;
        i_mean <= mv;
        i_std_dev <= sv;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        res = normal_cdf(xv, mv, sv);
        if (known) begin
            res.prob = prob;
            res.bad = bad;
        end
        pending_q.push_back(res);
        @(negedge i_clk);
    endtask

    initial begin
        logic [31:0] mv;
        logic [31:0] sv;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_x_value = '0;
        i_mean = '0;
        i_std_dev = '0;
        stim_done = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        add_row(32'h0, 32'h0, 32'h0, 1'b1, 25'd0, 1'b1);
        add_row(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 1'b1, 25'd0, 1'b1);
        add_row(32'h1234_5678, 32'h0, 32'hffff_ffff, 1'b1, 25'd0, 1'b1);
        add_row(32'h7fff_ffff, 32'h8000_0000, 32'h1, 1'b1, 25'h100_0000, 1'b0);
        add_row(32'h8000_0000, 32'h7fff_ffff, 32'h1, 1'b1, 25'd0, 1'b0);
        add_row(32'h0, 32'h0, 32'h1_0000, 1'b0, '0, 1'b0);
        add_row(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 1'b0, '0, 1'b0);
        add_row(32'h1_0000, 32'h0, 32'h1_0000, 1'b0, '0, 1'b0);
        add_row(32'hffff_0000, 32'h0, 32'h1_0000, 1'b0, '0, 1'b0);
        add_row(32'h2_0000, 32'h0, 32'h1_0000, 1'b0, '0, 1'b0);
        add_row(32'h0, 32'h3_0000, 32'h1_0000, 1'b0, '0, 1'b0);
        add_row(32'h1, 32'h0, 32'h7fff_ffff, 1'b0, '0, 1'b0);
        add_row(32'h0, 32'h1, 32'h7fff_ffff, 1'b0, '0, 1'b0);
        add_row(32'h7fff_ffff, 32'h0, 32'h7fff_ffff, 1'b0, '0, 1'b0);
        add_row(32'h8000_0000, 32'h0, 32'h7fff_ffff, 1'b0, '0, 1'b0);
        add_row(32'h8_0000, 32'h0, 32'h1_0000, 1'b0, '0, 1'b0);
        add_row(32'h0, 32'h8_0000, 32'h1_0000, 1'b0, '0, 1'b0);
        add_row(32'h4000, 32'h0, 32'h1_0000, 1'b0, '0, 1'b0);
        add_row(32'h5555_5555, 32'haaaa_aaaa, 32'h7fff_ffff, 1'b0, '0, 1'b0);

        foreach (directed_rows[k]) begin
            send_item(directed_rows[k].x_value, directed_rows[k].mean, directed_rows[k].std_dev,
                      directed_rows[k].known, directed_rows[k].prob, directed_rows[k].bad);
        end

        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            if (k == RANDOM_ITEMS / 2) begin
                i_valid <= 1'b0;
                @(negedge i_clk);
                while (pending_q.size() != 0) @(negedge i_clk);
            end
            sv = random_sigma();
            if ($urandom_range(0, 4) == 0) begin
                send_item($urandom(), $urandom(), sv, 1'b0, '0, 1'b0);
            end else begin
                mv = $urandom();
                send_item(mv + 32'(int'($urandom_range(0, 12 * 65536)) - 6 * 65536),
                          mv, sv, 1'b0, '0, 1'b0);
            end
        end
        i_valid <= 1'b0;
        stim_done = 1'b1;
    end

    initial begin
        int gap;
        i_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if ($urandom_range(0, 3) == 0) begin
                gap = gap_length();
                if (gap > 0) begin
                    i_ready <= 1'b0;
                    repeat (gap) @(negedge i_clk);
                end
            end
            i_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_cdf_res exp_res;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_q.size() == 0) begin
                $error("unexpected result: probability %0d bad_sigma %0d",
                       o_probability, o_bad_sigma);
                error_count++;
            end else begin
                exp_res = pending_q.pop_front();
                if (o_probability !== exp_res.prob) begin
                    $error("probability: expected %0d actual %0d", exp_res.prob, o_probability);
                    error_count++;
                end
                if (o_bad_sigma !== exp_res.bad) begin
                    $error("bad_sigma: expected %0d actual %0d", exp_res.bad, o_bad_sigma);
                    error_count++;
                end
            end
        end
    end

    initial begin
        error_count = 0;
        cycle_count = 0;
        fork
            begin
                wait (stim_done);
                while (pending_q.size() != 0) @(posedge i_clk);
                repeat (300) @(posedge i_clk);
            end
            begin
                while (cycle_count < CYCLE_LIMIT) begin
                    @(posedge i_clk);
                    cycle_count++;
                end
                error_count++;
            end
        join_any
        if (error_count == 0 && pending_q.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
`default_nettype wire
